// File: rtl/lzw_pkg.sv
// Shared constants, types and helpers for the LZW encoder.
`timescale 1ns / 1ps

package lzw_pkg;

  // Widest code the dictionary supports, and the widths that follow from it.
  localparam int MAX_CODE_BITS = 12;
  localparam int CODE_W        = MAX_CODE_BITS;
  localparam int BYTE_W        = 8;
  localparam int ENTRY_W       = CODE_W + BYTE_W;
  localparam int DICT_DEPTH    = 2 ** CODE_W;

  // First code that names a dictionary entry; codes below it are single bytes.
  localparam logic [CODE_W-1:0] FIRST_CODE = CODE_W'(256);

  // Code width register: reset value and clamp range.
  localparam logic [3:0] CODE_BITS_RESET = 4'd10;
  localparam logic [3:0] CODE_BITS_MIN   = 4'd9;
  localparam logic [3:0] CODE_BITS_MAX   = 4'(MAX_CODE_BITS);

  // Register word index of the code width register.
  localparam logic REG_CODE_BITS = 1'b0;

  // Request from the encoder control to the dictionary.
  typedef struct packed {
    logic               start;
    logic               wr_en;
    logic [CODE_W-1:0]  wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic [ENTRY_W-1:0] key;
    logic [CODE_W-1:0]  end_code;
  } dict_req_t;

  // Search status from the dictionary.
  typedef struct packed {
    logic              done;
    logic              hit;
    logic [CODE_W-1:0] hit_code;
  } dict_stat_t;

  // Number of codes in use at which the dictionary freezes: 2^bits - 1,
  // with the width clamped to the supported range.
  function automatic logic [CODE_W-1:0] code_limit(input logic [3:0] bits);
    logic [3:0] eff;
    eff = bits;
    if (eff < CODE_BITS_MIN) eff = CODE_BITS_MIN;
    if (eff > CODE_BITS_MAX) eff = CODE_BITS_MAX;
    return {CODE_W{1'b1}} >> (CODE_BITS_MAX - eff);
  endfunction

endpackage

// File: rtl/lzw_dict.sv
// Dictionary store of the LZW encoder with its sequential search unit.
`timescale 1ns / 1ps

module lzw_dict import lzw_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  dict_req_t  req,
  output dict_stat_t stat
);

  logic [ENTRY_W-1:0] mem [DICT_DEPTH];
  logic [ENTRY_W-1:0] rd_data;
  logic [CODE_W-1:0]  scan_addr;
  logic [CODE_W-1:0]  chk_code;
  logic               chk_valid;
  logic               busy;
  logic               issue;
  logic               match;

  // One read is issued per cycle; its data is compared in the cycle after.
  assign issue = busy && (scan_addr < req.end_code);
  assign match = chk_valid && (rd_data == req.key);

  assign stat.done     = busy && (match || (!chk_valid && !issue));
  assign stat.hit      = match;
  assign stat.hit_code = chk_code;

  // Search control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      chk_valid <= 1'b0;
    end else if (req.start) begin
      busy      <= 1'b1;
      chk_valid <= 1'b0;
    end else begin
      if (stat.done) begin
        busy <= 1'b0;
      end
      chk_valid <= issue;
    end
  end

  // Search address and the code of the entry under compare.
  always_ff @(posedge clk) begin
    if (req.start) begin
      scan_addr <= FIRST_CODE;
    end else if (issue) begin
      scan_addr <= scan_addr + CODE_W'(1);
      chk_code  <= scan_addr;
    end
  end

  // Entry memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (issue) begin
      rd_data <= mem[scan_addr];
    end
  end

endmodule

// File: rtl/lzw_encoder.sv
// Top level of the LZW encoder: control sequencer, code register and result queue.
//
//   Port group  Dir  Contents
//   s_*         in   byte words: tdata = data_byte, tlast = end_of_stream
//   m_*         out  code words: tdata = code (zero padded), tlast = last_code
//   APB         in   code_bits register at byte address 0
//
// The first byte of a stream is accepted and held as the prefix, or, when it also ends
// the stream, its code is queued. Any later byte is accepted, then the dictionary is
// searched over the entries in use, where the single memory read port looks at one entry
// per cycle and each read is compared in the following cycle, and its codes are queued
// when it releases any. A two-word output queue lets new bytes in while codes wait.
// Reset is synchronous and leaves the dictionary empty with code_bits at 10.
// A stalled output only holds the sequencer when the queue has no room.
`timescale 1ns / 1ps

module lzw_encoder import lzw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [11:0] code, [15:12] zero
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_PUSH = 3'b100
  } state_t;

  state_t              state, state_next;
  logic [3:0]          code_bits;
  logic [BYTE_W-1:0]   byte_r, byte_next;
  logic                last_r, last_next;
  logic [CODE_W-1:0]   prefix, prefix_next;
  logic                prefix_valid, prefix_valid_next;
  logic [CODE_W-1:0]   next_free, next_free_next;
  logic [CODE_W-1:0]   new_prefix;
  logic [1:0]          res_n, res_n_next;
  logic [CODE_W-1:0]   res0_code, res0_code_next;
  logic                res0_last, res0_last_next;
  logic [CODE_W-1:0]   res1_code, res1_code_next;
  logic [CODE_W-1:0]   q_code [2];
  logic                q_last [2];
  logic [CODE_W-1:0]   q_code_next [2];
  logic                q_last_next [2];
  logic [1:0]          q_cnt, q_cnt_next, cnt_p;
  logic                pop, push, room;
  logic                s_accept;
  logic                cfg_write;
  dict_req_t           req;
  dict_stat_t          stat;

  lzw_dict u_dict (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .stat (stat)
  );

  // Configuration register.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_CODE_BITS);
  assign prdata    = (paddr[2] == REG_CODE_BITS) ? {28'd0, code_bits} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      code_bits <= CODE_BITS_RESET;
    end else if (cfg_write) begin
      code_bits <= pwdata[3:0];
    end
  end

  // Handshakes.
  assign s_tready = (state == ST_IDLE);
  assign s_accept = s_tvalid && s_tready;
  assign m_tvalid = (q_cnt != 2'd0);
  assign m_tdata  = {{(16 - CODE_W){1'b0}}, q_code[0]};
  assign m_tlast  = q_last[0];
  assign pop      = m_tvalid && m_tready;

  // Sequencer: take a byte, search the dictionary, settle the codes.
  always_comb begin
    state_next        = state;
    byte_next         = byte_r;
    last_next         = last_r;
    prefix_next       = prefix;
    prefix_valid_next = prefix_valid;
    next_free_next    = next_free;
    res_n_next        = res_n;
    res0_code_next    = res0_code;
    res0_last_next    = res0_last;
    res1_code_next    = res1_code;
    new_prefix        = prefix;
    req.start         = 1'b0;
    req.wr_en         = 1'b0;
    req.wr_addr       = next_free;
    req.key           = {prefix, byte_r};
    req.wr_data       = {prefix, byte_r};
    req.end_code      = next_free;
    case (state)
      ST_IDLE: begin
        if (s_accept) begin
          byte_next = s_tdata;
          last_next = s_tlast;
          if (prefix_valid) begin
            req.start  = 1'b1;
            state_next = ST_SCAN;
          end else if (s_tlast) begin
            // Single-byte stream: the byte itself is the final code.
            res_n_next     = 2'd1;
            res0_code_next = {{(CODE_W - BYTE_W){1'b0}}, s_tdata};
            res0_last_next = 1'b1;
            next_free_next = FIRST_CODE;
            state_next     = ST_PUSH;
          end else begin
            prefix_next       = {{(CODE_W - BYTE_W){1'b0}}, s_tdata};
            prefix_valid_next = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        if (stat.done) begin
          if (stat.hit) begin
            new_prefix = stat.hit_code;
            res_n_next = 2'd0;
          end else begin
            // Miss: send the prefix, add the new entry unless frozen.
            new_prefix     = {{(CODE_W - BYTE_W){1'b0}}, byte_r};
            res_n_next     = 2'd1;
            res0_code_next = prefix;
            res0_last_next = 1'b0;
            if (next_free < code_limit(code_bits)) begin
              req.wr_en      = 1'b1;
              next_free_next = next_free + CODE_W'(1);
            end
          end
          if (last_r) begin
            // Flush the remaining prefix and clear for a new stream.
            if (stat.hit) begin
              res_n_next     = 2'd1;
              res0_code_next = new_prefix;
              res0_last_next = 1'b1;
            end else begin
              res_n_next     = 2'd2;
              res1_code_next = new_prefix;
            end
            prefix_next       = '0;
            prefix_valid_next = 1'b0;
            next_free_next    = FIRST_CODE;
            state_next        = ST_PUSH;
          end else begin
            prefix_next = new_prefix;
            state_next  = stat.hit ? ST_IDLE : ST_PUSH;
          end
        end
      end
      ST_PUSH: begin
        if (room) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Result queue: pop the head, then append the settled codes.
  always_comb begin
    q_code_next = q_code;
    q_last_next = q_last;
    cnt_p       = q_cnt;
    if (pop) begin
      q_code_next[0] = q_code[1];
      q_last_next[0] = q_last[1];
      cnt_p          = q_cnt - 2'd1;
    end
    room       = ({1'b0, cnt_p} + {1'b0, res_n}) <= 3'd2;
    push       = (state == ST_PUSH) && room;
    q_cnt_next = cnt_p;
    if (push) begin
      q_code_next[cnt_p[0]] = res0_code;
      q_last_next[cnt_p[0]] = res0_last;
      if (res_n == 2'd2) begin
        q_code_next[1] = res1_code;
        q_last_next[1] = 1'b1;
      end
      q_cnt_next = cnt_p + res_n;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      prefix       <= '0;
      prefix_valid <= 1'b0;
      next_free    <= FIRST_CODE;
      q_cnt        <= 2'd0;
      res_n        <= 2'd0;
    end else begin
      state        <= state_next;
      prefix       <= prefix_next;
      prefix_valid <= prefix_valid_next;
      next_free    <= next_free_next;
      q_cnt        <= q_cnt_next;
      res_n        <= res_n_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    byte_r    <= byte_next;
    last_r    <= last_next;
    res0_code <= res0_code_next;
    res0_last <= res0_last_next;
    res1_code <= res1_code_next;
    q_code    <= q_code_next;
    q_last    <= q_last_next;
  end

  // Checks on the sequencer and queue.
  a_qcnt_range: assert property (@(posedge clk) disable iff (rst) q_cnt != 2'd3)
    else $error("result queue count out of range");

  a_free_floor: assert property (@(posedge clk) disable iff (rst)
    next_free >= FIRST_CODE)
    else $error("next free code below first dictionary code");

  a_done_in_scan: assert property (@(posedge clk) disable iff (rst)
    stat.done |-> state == ST_SCAN)
    else $error("dictionary search finished outside the search state");

  a_prefix_clear: assert property (@(posedge clk) disable iff (rst)
    !prefix_valid |-> prefix == '0)
    else $error("stale prefix code while no prefix is held");

endmodule
